// ----- design/bzp_pkg.sv -----
package bzp_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;

  localparam logic [11:0] ZOOM_MIN_Q8 = 12'd256;
  localparam logic [11:0] ZOOM_MAX_Q8 = 12'd2560;

  // One quotient bit per divider stage.
  localparam int QUOT_BITS = 24;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_PRODUCE = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    REG_IN_WIDTH   = 3'd0,
    REG_IN_HEIGHT  = 3'd1,
    REG_OUT_WIDTH  = 3'd2,
    REG_OUT_HEIGHT = 3'd3,
    REG_SHIFT_X    = 3'd4,
    REG_SHIFT_Y    = 3'd5
  } cfg_reg_t;

  // Classified item as it sits in the queue.
  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic [7:0]  sample;
    logic [15:0] pan_x;
    logic [15:0] pan_y;
    logic [15:0] prod_x;
    logic [15:0] prod_y;
    logic [19:0] den_x;
    logic [19:0] den_y;
    logic [7:0]  xmax;
    logic [7:0]  ymax;
  } entry_t;

  // Fields that ride along the divider stages untouched.
  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic [7:0]  sample;
    logic [15:0] pan_x;
    logic [15:0] pan_y;
    logic [7:0]  xmax;
    logic [7:0]  ymax;
  } item_t;

  // Partial state of one restoring division.
  typedef struct packed {
    logic [19:0]          rem;
    logic [19:0]          den;
    logic [7:0]           lo;
    logic [QUOT_BITS-1:0] quot;
  } div_t;

  typedef struct packed {
    logic [7:0] i0;
    logic [7:0] i1;
    logic [7:0] f;
  } tap_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [8:0] clamp_size(logic [8:0] v, logic [8:0] hi);
    logic [8:0] r;
    if (v == 9'd0) r = 9'd1;
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

  function automatic logic [1:0] clamp_shift(logic [1:0] s);
    return (s == 2'd3) ? 2'd2 : s;
  endfunction

  function automatic logic [8:0] ceil_shift(logic [8:0] v, logic [1:0] s);
    logic [9:0] t;
    t = {1'b0, v} + ((10'd1 << s) - 10'd1);
    return 9'(t >> s);
  endfunction

  // The dividend is prod * 2^16; its top byte seeds the remainder, the
  // rest is shifted in one bit per stage (the low 16 bits are zero).
  function automatic div_t div_start(logic [15:0] prod, logic [19:0] den);
    div_t d;
    d.rem  = {12'd0, prod[15:8]};
    d.den  = den;
    d.lo   = prod[7:0];
    d.quot = '0;
    return d;
  endfunction

  function automatic div_t div_step(div_t d);
    logic [20:0] t;
    div_t n;
    t = {d.rem, d.lo[7]};
    n = d;
    n.lo = {d.lo[6:0], 1'b0};
    if (t >= {1'b0, d.den}) begin
      n.rem  = 20'(t - {1'b0, d.den});
      n.quot = {d.quot[QUOT_BITS-2:0], 1'b1};
    end else begin
      n.rem  = t[19:0];
      n.quot = {d.quot[QUOT_BITS-2:0], 1'b0};
    end
    return n;
  endfunction

  // Source position in Q8.8, then the two neighbour indexes clamped to
  // the plane edge and the fraction.
  function automatic tap_t map_taps(logic [15:0] pan, logic [QUOT_BITS-1:0] quot,
                                    logic [7:0] maxi);
    logic [24:0] src;
    tap_t t;
    src = {9'd0, pan} + {1'b0, quot};
    if (src[24:8] > {9'd0, maxi}) t.i0 = maxi;
    else t.i0 = src[15:8];
    t.i1 = (t.i0 == maxi) ? t.i0 : t.i0 + 8'd1;
    t.f  = src[7:0];
    return t;
  endfunction

  function automatic logic [7:0] pick4(logic [1:0] s, logic [7:0] a0, logic [7:0] a1,
                                       logic [7:0] a2, logic [7:0] a3);
    logic [7:0] r;
    case (s)
      2'd0:    r = a0;
      2'd1:    r = a1;
      2'd2:    r = a2;
      default: r = a3;
    endcase
    return r;
  endfunction

endpackage

// ----- design/bzp_front.sv -----
module bzp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [8:0]        cfg_data,
  input  logic [71:0]       tdata,  // pos_x, pos_y, sample_in, zoom_q8, pan_x_q8, pan_y_q8
  input  logic              tuser,  // command
  output bzp_pkg::entry_t   entry
);

  logic [8:0] in_width, in_height, out_width, out_height;
  logic [1:0] shift_x, shift_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_width   <= 9'd256;
      in_height  <= 9'd256;
      out_width  <= 9'd256;
      out_height <= 9'd256;
      shift_x    <= 2'd0;
      shift_y    <= 2'd0;
    end else if (cfg_we) begin
      unique case (bzp_pkg::cfg_reg_t'(cfg_index))
        bzp_pkg::REG_IN_WIDTH:   in_width   <= cfg_data;
        bzp_pkg::REG_IN_HEIGHT:  in_height  <= cfg_data;
        bzp_pkg::REG_OUT_WIDTH:  out_width  <= cfg_data;
        bzp_pkg::REG_OUT_HEIGHT: out_height <= cfg_data;
        bzp_pkg::REG_SHIFT_X:    shift_x    <= cfg_data[1:0];
        bzp_pkg::REG_SHIFT_Y:    shift_y    <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic [7:0]  pos_x, pos_y, sample;
  logic [11:0] zoom_raw, zoom;
  logic [15:0] pan_x_raw, pan_y_raw, pan_max_x, pan_max_y;
  logic [8:0]  lw, lh, low, loh, iw, ih, ow, oh, lw_m1, lh_m1, iw_m1, ih_m1;
  logic [1:0]  sx, sy;
  logic [16:0] prod_x, prod_y;
  logic [20:0] den_x, den_y;

  assign pos_x     = tdata[7:0];
  assign pos_y     = tdata[15:8];
  assign sample    = tdata[23:16];
  assign zoom_raw  = tdata[35:24];
  assign pan_x_raw = tdata[51:36];
  assign pan_y_raw = tdata[67:52];

  always_comb begin
    lw  = bzp_pkg::clamp_size(in_width,   9'(bzp_pkg::MAX_WIDTH));
    lh  = bzp_pkg::clamp_size(in_height,  9'(bzp_pkg::MAX_HEIGHT));
    low = bzp_pkg::clamp_size(out_width,  9'(bzp_pkg::MAX_WIDTH));
    loh = bzp_pkg::clamp_size(out_height, 9'(bzp_pkg::MAX_HEIGHT));
    sx  = bzp_pkg::clamp_shift(shift_x);
    sy  = bzp_pkg::clamp_shift(shift_y);
    iw  = bzp_pkg::ceil_shift(lw, sx);
    ih  = bzp_pkg::ceil_shift(lh, sy);
    ow  = bzp_pkg::ceil_shift(low, sx);
    oh  = bzp_pkg::ceil_shift(loh, sy);

    lw_m1 = lw - 9'd1;
    lh_m1 = lh - 9'd1;
    iw_m1 = iw - 9'd1;
    ih_m1 = ih - 9'd1;
    pan_max_x = {lw_m1[7:0], 8'h00};
    pan_max_y = {lh_m1[7:0], 8'h00};

    if (zoom_raw < bzp_pkg::ZOOM_MIN_Q8) zoom = bzp_pkg::ZOOM_MIN_Q8;
    else if (zoom_raw > bzp_pkg::ZOOM_MAX_Q8) zoom = bzp_pkg::ZOOM_MAX_Q8;
    else zoom = zoom_raw;

    prod_x = {8'd0, iw} * {9'd0, pos_x};
    prod_y = {8'd0, ih} * {9'd0, pos_y};
    den_x  = {9'd0, zoom} * {12'd0, ow};
    den_y  = {9'd0, zoom} * {12'd0, oh};

    entry.cmd    = bzp_pkg::cmd_t'(tuser);
    entry.pos_x  = pos_x;
    entry.pos_y  = pos_y;
    entry.sample = sample;
    entry.pan_x  = ((pan_x_raw > pan_max_x) ? pan_max_x : pan_x_raw) >> sx;
    entry.pan_y  = ((pan_y_raw > pan_max_y) ? pan_max_y : pan_y_raw) >> sy;
    entry.prod_x = prod_x[15:0];
    entry.prod_y = prod_y[15:0];
    entry.den_x  = den_x[19:0];
    entry.den_y  = den_y[19:0];
    entry.xmax   = iw_m1[7:0];
    entry.ymax   = ih_m1[7:0];
  end

endmodule

// ----- design/bzp_queue.sv -----
module bzp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  bzp_pkg::entry_t   din,
  input  logic              pop,
  output bzp_pkg::entry_t   dout,
  output bzp_pkg::q_stat_t  stat
);

  bzp_pkg::entry_t slots [0:bzp_pkg::QUEUE_DEPTH-1];
  logic [bzp_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [bzp_pkg::QPTR_W:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= din;
  end

  assign dout       = slots[rd_ptr];
  assign stat.full  = (count == (bzp_pkg::QPTR_W+1)'(bzp_pkg::QUEUE_DEPTH));
  assign stat.empty = (count == '0);

endmodule

// ----- design/bzp_back.sv -----
module bzp_back (
  input  logic             clk,
  input  logic             rst,
  input  bzp_pkg::entry_t  q_data,
  input  logic             q_empty,
  output logic             q_pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [23:0]      m_tdata
);

  localparam int NST = bzp_pkg::QUOT_BITS + 1;

  // The whole back pipeline moves together whenever the output register
  // is free or being emptied.
  logic en;
  assign en    = !m_tvalid || m_tready;
  assign q_pop = en && !q_empty;

  // Divider stages: stage j holds the state after j quotient bits.
  logic           dv [0:NST-1];
  bzp_pkg::item_t di [0:NST-1];
  bzp_pkg::div_t  dx [0:NST-1];
  bzp_pkg::div_t  dy [0:NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < NST; j++) dv[j] <= 1'b0;
    end else if (en) begin
      dv[0] <= !q_empty;
      for (int j = 0; j < NST-1; j++) dv[j+1] <= dv[j];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      di[0].cmd    <= q_data.cmd;
      di[0].pos_x  <= q_data.pos_x;
      di[0].pos_y  <= q_data.pos_y;
      di[0].sample <= q_data.sample;
      di[0].pan_x  <= q_data.pan_x;
      di[0].pan_y  <= q_data.pan_y;
      di[0].xmax   <= q_data.xmax;
      di[0].ymax   <= q_data.ymax;
      dx[0] <= bzp_pkg::div_start(q_data.prod_x, q_data.den_x);
      dy[0] <= bzp_pkg::div_start(q_data.prod_y, q_data.den_y);
      for (int j = 0; j < NST-1; j++) begin
        di[j+1] <= di[j];
        dx[j+1] <= bzp_pkg::div_step(dx[j]);
        dy[j+1] <= bzp_pkg::div_step(dy[j]);
      end
    end
  end

  // Tap stage: neighbour indexes and fractions.
  logic           sav;
  bzp_pkg::item_t sa_item;
  bzp_pkg::tap_t  tx, ty;

  always_ff @(posedge clk) begin
    if (rst) sav <= 1'b0;
    else if (en) sav <= dv[NST-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_item <= di[NST-1];
      tx <= bzp_pkg::map_taps(di[NST-1].pan_x, dx[NST-1].quot, di[NST-1].xmax);
      ty <= bzp_pkg::map_taps(di[NST-1].pan_y, dy[NST-1].quot, di[NST-1].ymax);
    end
  end

  // Store: four banks split by row and column parity, so the four
  // neighbours always fall in distinct banks (or repeat at an edge).
  logic [7:0]  col_sel [0:1];
  logic [7:0]  row_sel [0:1];
  logic [1:0]  wbank;
  logic [13:0] waddr;
  logic        wen;
  logic [7:0]  rd [0:3];

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      col_sel[p] = (tx.i0[0] == p[0]) ? tx.i0 : tx.i1;
      row_sel[p] = (ty.i0[0] == p[0]) ? ty.i0 : ty.i1;
    end
    wbank = {sa_item.pos_y[0], sa_item.pos_x[0]};
    waddr = {sa_item.pos_y[7:1], sa_item.pos_x[7:1]};
    wen   = en && sav && (sa_item.cmd == bzp_pkg::CMD_LOAD);
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [7:0] mem [0:16383];
    logic [13:0] raddr;
    assign raddr = {row_sel[b >> 1][7:1], col_sel[b & 1][7:1]};
    always_ff @(posedge clk) begin
      if (wen && wbank == 2'(b)) mem[waddr] <= sa_item.sample;
      if (en && sav) rd[b] <= mem[raddr];
    end
  end

  // Weight stage runs beside the memory read.
  logic        mv;
  bzp_pkg::cmd_t m_cmd;
  logic [7:0]  m_col, m_row;
  logic [1:0]  s00, s10, s01, s11;
  logic [16:0] w00, w10, w01, w11;
  logic [8:0]  wx0, wy0, wx1, wy1;
  logic [17:0] pw00, pw10, pw01, pw11;

  always_comb begin
    wx0  = 9'd256 - {1'b0, tx.f};
    wy0  = 9'd256 - {1'b0, ty.f};
    wx1  = {1'b0, tx.f};
    wy1  = {1'b0, ty.f};
    pw00 = wx0 * wy0;
    pw10 = wx1 * wy0;
    pw01 = wx0 * wy1;
    pw11 = wx1 * wy1;
  end

  always_ff @(posedge clk) begin
    if (rst) mv <= 1'b0;
    else if (en) mv <= sav;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_cmd <= sa_item.cmd;
      m_col <= sa_item.pos_x;
      m_row <= sa_item.pos_y;
      s00   <= {ty.i0[0], tx.i0[0]};
      s10   <= {ty.i0[0], tx.i1[0]};
      s01   <= {ty.i1[0], tx.i0[0]};
      s11   <= {ty.i1[0], tx.i1[0]};
      w00   <= pw00[16:0];
      w10   <= pw10[16:0];
      w01   <= pw01[16:0];
      w11   <= pw11[16:0];
    end
  end

  // Product stage.
  logic          pv;
  bzp_pkg::cmd_t p_cmd;
  logic [7:0]    p_col, p_row;
  logic [24:0]   p00, p10, p01, p11;

  always_ff @(posedge clk) begin
    if (rst) pv <= 1'b0;
    else if (en) pv <= mv;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_cmd <= m_cmd;
      p_col <= m_col;
      p_row <= m_row;
      p00 <= {17'd0, bzp_pkg::pick4(s00, rd[0], rd[1], rd[2], rd[3])} * {8'd0, w00};
      p10 <= {17'd0, bzp_pkg::pick4(s10, rd[0], rd[1], rd[2], rd[3])} * {8'd0, w10};
      p01 <= {17'd0, bzp_pkg::pick4(s01, rd[0], rd[1], rd[2], rd[3])} * {8'd0, w01};
      p11 <= {17'd0, bzp_pkg::pick4(s11, rd[0], rd[1], rd[2], rd[3])} * {8'd0, w11};
    end
  end

  // Sum, round and output register.
  logic [25:0] acc;
  assign acc = {1'b0, p00} + {1'b0, p10} + {1'b0, p01} + {1'b0, p11} + 26'd32768;

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= pv && (p_cmd == bzp_pkg::CMD_PRODUCE);
  end

  always_ff @(posedge clk) begin
    if (en) m_tdata <= {p_row, p_col, acc[23:16]};
  end

endmodule

// ----- design/bilinear_zoom_pan_sampler_unit.sv -----
// Bilinear zoom and pan sampler for one 8-bit plane. Beats with tuser low
// load one source sample at (pos_x, pos_y); beats with tuser high produce one
// output beat holding the rounded bilinear blend of the four source samples
// around pan + plane_in * pos / (zoom * plane_out), in Q8.8, together with
// the echoed column and row. Loads produce no output beat. The block takes
// one beat per clock while the queue is not full and returns one result per
// clock while m_tready stays high; a produce beat reaches the output through
// the pipelined divider that forms the source coordinate. A four-entry
// queue sits between the input classifier and the compute pipeline, and it
// takes beats until full while a finished result waits in the output register.
// The source plane lives in four parity banks (even/odd row by even/odd column)
// so all four neighbours are read in parallel; samples are undefined until
// loaded, and a load is seen by every produce beat accepted after it.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and
// must only change while no beat is in flight.
module bilinear_zoom_pan_sampler_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // pos_x[7:0], pos_y[15:8], sample_in[23:16], zoom_q8[35:24],
  // pan_x_q8[51:36], pan_y_q8[67:52], zero fill above
  input  logic [71:0] s_tdata,
  input  logic        s_tuser,   // command
  output logic        m_tvalid,
  input  logic        m_tready,
  // sample_out[7:0], out_col[15:8], out_row[23:16]
  output logic [23:0] m_tdata
);

  bzp_pkg::entry_t  entry, q_data;
  bzp_pkg::q_stat_t q_stat;
  logic             push, q_pop;

  assign s_tready = !q_stat.full;
  assign push     = s_tvalid && s_tready;

  bzp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tdata     (s_tdata),
    .tuser     (s_tuser),
    .entry     (entry)
  );

  bzp_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (entry),
    .pop  (q_pop),
    .dout (q_data),
    .stat (q_stat)
  );

  bzp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_data   (q_data),
    .q_empty  (q_stat.empty),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // The queue can only fill up because of a beat that was pushed.
  a_full_after_push: assert property (@(posedge clk) disable iff (rst)
    $fell(s_tready) |-> $past(s_tvalid))
    else $error("input side stalled without a beat being taken");

  // Full and empty never both hold.
  a_queue_state: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  // An empty queue stays empty unless a beat is pushed.
  a_empty_holds: assert property (@(posedge clk) disable iff (rst)
    (q_stat.empty && !push) |=> q_stat.empty)
    else $error("queue filled without a push");

endmodule

// ----- bench/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 64;
  localparam int STALL_LIMIT  = 20000;

  // Per-pixel output beat as the block should return it.
  typedef struct packed {
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] sample;
  } pixel_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [8:0]  cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;

  bilinear_zoom_pan_sampler_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  // Shadow copy of the block state used by the predictor.
  logic [7:0] plane_copy [0:bzp_pkg::MAX_WIDTH*bzp_pkg::MAX_HEIGHT-1];
  logic [8:0] cur_in_w, cur_in_h, cur_out_w, cur_out_h;
  logic [1:0] cur_shift_x, cur_shift_y;

  pixel_t pending_pixels[$];
  int     mismatch_count;
  int     idle_cycles;
  bit     timed_out;
  bit     hold_sink;      // long receiver hold-off requested
  int     hold_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Map one axis to its source position in Q8.8 plane coordinates.
  function automatic longint unsigned axis_src(int unsigned pan_q8, int unsigned luma_in,
                                               int unsigned luma_out, int unsigned shift,
                                               int unsigned pos, int unsigned zoom,
                                               int unsigned plane_in);
    int unsigned pan_lim, pan, plane_out;
    longint unsigned num, den;
    pan_lim = (luma_in - 1) << 8;
    pan = (pan_q8 > pan_lim ? pan_lim : pan_q8) >> shift;
    plane_out = (luma_out + (1 << shift) - 1) >> shift;
    num = longint'(plane_in) * pos * 65536;
    den = longint'(zoom) * plane_out;
    return pan + num / den;
  endfunction

  function automatic int unsigned clamp_luma(logic [8:0] v);
    if (v == 0) return 1;
    if (v > 256) return 256;
    return v;
  endfunction

  // Bilinear blend of the four neighbors with edge clamping, half rounded up.
  function automatic pixel_t blend_pixel(logic [7:0] px, logic [7:0] py, logic [11:0] zq,
                                         logic [15:0] pan_x, logic [15:0] pan_y);
    int unsigned lw, lh, low, loh, sx, sy, iw, ih, zoom;
    longint unsigned sxq, syq;
    int unsigned ix, iy, ix1, iy1, fx, fy, acc;
    pixel_t p;
    lw = clamp_luma(cur_in_w);
    lh = clamp_luma(cur_in_h);
    low = clamp_luma(cur_out_w);
    loh = clamp_luma(cur_out_h);
    sx = (cur_shift_x == 3) ? 2 : cur_shift_x;
    sy = (cur_shift_y == 3) ? 2 : cur_shift_y;
    iw = (lw + (1 << sx) - 1) >> sx;
    ih = (lh + (1 << sy) - 1) >> sy;
    zoom = zq < bzp_pkg::ZOOM_MIN_Q8 ? bzp_pkg::ZOOM_MIN_Q8 :
           (zq > bzp_pkg::ZOOM_MAX_Q8 ? bzp_pkg::ZOOM_MAX_Q8 : zq);
    sxq = axis_src(pan_x, lw, low, sx, px, zoom, iw);
    syq = axis_src(pan_y, lh, loh, sy, py, zoom, ih);
    fx = sxq & 255;
    fy = syq & 255;
    ix = (sxq >> 8) > iw - 1 ? iw - 1 : int'(sxq >> 8);
    iy = (syq >> 8) > ih - 1 ? ih - 1 : int'(syq >> 8);
    ix1 = ix + 1 > iw - 1 ? iw - 1 : ix + 1;
    iy1 = iy + 1 > ih - 1 ? ih - 1 : iy + 1;
    acc = plane_copy[iy*256+ix] * (256 - fx) * (256 - fy)
        + plane_copy[iy*256+ix1] * fx * (256 - fy)
        + plane_copy[iy1*256+ix] * (256 - fx) * fy
        + plane_copy[iy1*256+ix1] * fx * fy;
    p.sample = 8'((acc + 32768) >> 16);
    p.col = px;
    p.row = py;
    return p;
  endfunction

  // Register writes happen only while idle, so they update the shadow at once.
  task automatic write_reg(bzp_pkg::cfg_reg_t idx, logic [8:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      bzp_pkg::REG_IN_WIDTH:   cur_in_w = val;
      bzp_pkg::REG_IN_HEIGHT:  cur_in_h = val;
      bzp_pkg::REG_OUT_WIDTH:  cur_out_w = val;
      bzp_pkg::REG_OUT_HEIGHT: cur_out_h = val;
      bzp_pkg::REG_SHIFT_X:    cur_shift_x = val[1:0];
      default:                 cur_shift_y = val[1:0];
    endcase
  endtask

  // Sends one beat after a random gap; the prediction is made on acceptance.
  // Valid stays high after the beat so a following beat can go back to back.
  task automatic send_beat(bzp_pkg::cmd_t cmd, logic [7:0] px, logic [7:0] py,
                           logic [7:0] smp, logic [11:0] zq, logic [15:0] pan_x,
                           logic [15:0] pan_y, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {4'd0, pan_y, pan_x, zq, smp, py, px};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (cmd == bzp_pkg::CMD_LOAD) begin
      plane_copy[py*256+px] = smp;
    end else begin
      pending_pixels.push_back(blend_pixel(px, py, zq, pan_x, pan_y));
    end
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_pixels.size() != 0 && !timed_out) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Loads the whole active plane so every produce reads written samples.
  task automatic fill_plane(int unsigned w, int unsigned h, bit ramp);
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++)
        send_beat(bzp_pkg::CMD_LOAD, 8'(x), 8'(y),
                  ramp ? 8'((x * 37 + y * 11) ^ (x == 0 ? 255 : 0)) : 8'($urandom),
                  12'd0, 16'd0, 16'd0, 1'b1);
  endtask

  function automatic logic [15:0] rand_pan();
    case ($urandom_range(0, 3))
      0: return 16'd0;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [11:0] rand_zoom();
    case ($urandom_range(0, 4))
      0: return 12'd0;
      1: return 12'hFFF;
      2: return bzp_pkg::ZOOM_MIN_Q8;
      default: return 12'($urandom);
    endcase
  endfunction

  // Sets all six registers; sizes are luma pixels.
  task automatic set_geometry(logic [8:0] iw, logic [8:0] ih, logic [8:0] ow,
                              logic [8:0] oh, logic [1:0] sx, logic [1:0] sy);
    write_reg(bzp_pkg::REG_IN_WIDTH, iw);
    write_reg(bzp_pkg::REG_IN_HEIGHT, ih);
    write_reg(bzp_pkg::REG_OUT_WIDTH, ow);
    write_reg(bzp_pkg::REG_OUT_HEIGHT, oh);
    write_reg(bzp_pkg::REG_SHIFT_X, {7'd0, sx});
    write_reg(bzp_pkg::REG_SHIFT_Y, {7'd0, sy});
  endtask

  // Directed corners: tiny plane, extreme zoom and pan, out-of-range output
  // positions, shift value three and size zero.
  task automatic test_directed();
    set_geometry(9'd0, 9'd3, 9'd256, 9'd0, 2'd3, 2'd1);
    fill_plane(4, 4, 1);
    send_beat(bzp_pkg::CMD_PRODUCE, 8'd0, 8'd0, 8'hAA, 12'd0, 16'd0, 16'd0);
    send_beat(bzp_pkg::CMD_PRODUCE, 8'd255, 8'd255, 8'h55, 12'hFFF, 16'hFFFF, 16'hFFFF);
    send_beat(bzp_pkg::CMD_PRODUCE, 8'd1, 8'd2, 8'hFF, bzp_pkg::ZOOM_MAX_Q8,
              16'h0080, 16'h0180);
    send_beat(bzp_pkg::CMD_PRODUCE, 8'd3, 8'd1, 8'h00, 12'd300, 16'h00FF, 16'h0101);
    drain();
    set_geometry(9'd4, 9'd4, 9'd3, 9'd511, 2'd0, 2'd3);
    send_beat(bzp_pkg::CMD_PRODUCE, 8'd2, 8'd1, 8'd0, 12'd256, 16'h0140, 16'h00C0);
    send_beat(bzp_pkg::CMD_PRODUCE, 8'd255, 8'd0, 8'd0, 12'd511, 16'd0, 16'hFFFF);
    send_beat(bzp_pkg::CMD_PRODUCE, 8'd128, 8'd77, 8'd0, 12'd2561, 16'h8000, 16'd1);
    drain();
  endtask

  // Random phase: fill a plane, then mostly produce beats with some reloads.
  task automatic test_random_phase(logic [8:0] iw, logic [8:0] ih, logic [8:0] ow,
                                   logic [8:0] oh, logic [1:0] sx, logic [1:0] sy,
                                   int produces);
    int unsigned pw, ph;
    set_geometry(iw, ih, ow, oh, sx, sy);
    pw = (clamp_luma(iw) + (1 << (sx == 3 ? 2 : sx)) - 1) >> (sx == 3 ? 2 : sx);
    ph = (clamp_luma(ih) + (1 << (sy == 3 ? 2 : sy)) - 1) >> (sy == 3 ? 2 : sy);
    fill_plane(pw, ph, 0);
    for (int i = 0; i < produces; i++) begin
      if ($urandom_range(0, 5) == 0)
        send_beat(bzp_pkg::CMD_LOAD, 8'($urandom), 8'($urandom), 8'($urandom),
                  12'($urandom), 16'($urandom), 16'($urandom));
      else
        send_beat(bzp_pkg::CMD_PRODUCE, 8'($urandom), 8'($urandom), 8'($urandom),
                  rand_zoom(), rand_pan(), rand_pan());
    end
    drain();
  endtask

  // Receiver holds off while the sender keeps offering back-to-back beats.
  task automatic test_backpressure();
    set_geometry(9'd8, 9'd8, 9'd8, 9'd8, 2'd0, 2'd0);
    fill_plane(8, 8, 0);
    drain();
    hold_cycles = 200;
    hold_sink = 1'b1;
    for (int i = 0; i < 60; i++)
      send_beat(bzp_pkg::CMD_PRODUCE, 8'($urandom_range(0, 9)), 8'($urandom_range(0, 9)),
                8'($urandom), rand_zoom(), rand_pan(), rand_pan(), 1'b1);
    drain();
  endtask

  // Receiver: random stall per beat, plus the long hold-off when asked.
  initial begin
    int unsigned wait_n;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_sink) begin
        m_tready <= 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_sink = 1'b0;
      end
      wait_n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
      if (wait_n != 0) begin
        m_tready <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!(m_tvalid && m_tready) && !hold_sink) @(posedge clk);
    end
  end

  // Result checker: every accepted output beat against the oldest prediction.
  initial begin
    pixel_t want, got;
    mismatch_count = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got = m_tdata;
        if (pending_pixels.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected output beat %h", m_tdata);
        end else begin
          want = pending_pixels.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("pixel (%0d,%0d): expected sample %0d col %0d row %0d, got %0d %0d %0d",
                       want.col, want.row, want.sample, want.col, want.row,
                       got.sample, got.col, got.row);
          end
        end
      end
    end
  end

  // Watchdog: cycles with no beat accepted on either side, no reset and no register write.
  initial begin
    idle_cycles = 0;
    timed_out = 1'b0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst || cfg_we)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        timed_out = 1'b1;
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = bzp_pkg::REG_IN_WIDTH;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = bzp_pkg::CMD_LOAD;
    hold_sink = 1'b0;
    hold_cycles = 0;
    cur_in_w = 256;
    cur_in_h = 256;
    cur_out_w = 256;
    cur_out_h = 256;
    cur_shift_x = 0;
    cur_shift_y = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random_phase(9'd5, 9'd7, 9'd16, 9'd4, 2'd0, 2'd0, 300);
    test_random_phase(9'd1, 9'd1, 9'd1, 9'd1, 2'd2, 2'd2, 150);
    test_random_phase(9'd16, 9'd9, 9'd200, 9'd256, 2'd1, 2'd2, 350);
    test_random_phase(9'd256, 9'd2, 9'd2, 9'd256, 2'd2, 2'd0, 250);
    test_random_phase(9'd3, 9'd256, 9'd100, 9'd7, 2'd3, 2'd1, 250);
    test_random_phase(9'd12, 9'd12, 9'd12, 9'd12, 2'd1, 2'd1, 200);
    test_backpressure();

    if (mismatch_count == 0 && pending_pixels.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
